@@ rtl/core/lgs_pkg.sv @@
package lgs_pkg;

   // Fixed field widths of the stream words
   localparam int CELL_WORD_BITS  = 64;
   localparam int ROW_INDEX_BITS  = 12;
   localparam int WIDTH_CSR_BITS  = 7;
   localparam int RSP_TDATA_BITS  = 80;

   // Defaults for the top-level parameters
   localparam int DEF_ROW_BITS    = 64;
   localparam int DEF_MAX_ROWS    = 4096;

   // Reset value of the row width register
   localparam logic [WIDTH_CSR_BITS-1:0] WIDTH_RESET = 7'd64;

   // B3/S23 rule
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Result queue geometry
   localparam int RESULT_DEPTH    = 4;
   localparam int RESULT_PTR_BITS = 2;
   localparam int RESULT_CNT_BITS = 3;

   // 3x3 neighborhood of one cell; bit 1 of each row is the cell's own column
   typedef struct packed {
      logic [2:0] up;
      logic [2:0] mid;
      logic [2:0] dn;
   } nbhd_type;

   // One result word as held in the queue
   typedef struct packed {
      logic                      board_end;
      logic [ROW_INDEX_BITS-1:0] row_index;
      logic [CELL_WORD_BITS-1:0] next_row;
   } result_type;

endpackage

@@ rtl/core/life_generation_step.sv @@
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+---------------------------------------
// req_      | in        | req_tvalid / req_tready | tdata: cell_row; tlast: last_row
// rsp_      | out       | rsp_tvalid / rsp_tready | tdata: next_row, row_index; tlast: board_end
// csr_      | in        | csr_we                  | csr_wdata: row_width
//
// One row word is taken per cycle while req_tready is high; a row's result word
// is queued when the row below it is taken and is registered in the queue before rsp_.
// A row word marked last yields the flushed bottom row, after the pending row if held.
// Results wait in a four-entry queue; req_tready drops while fewer than two slots are free.
// With rsp_tready held high the block sustains one row word per cycle; a last-row word
// adds one more result word. Reset is synchronous, active high, and starts a new board.
module life_generation_step #(
   parameter int ROW_BITS = lgs_pkg::DEF_ROW_BITS,
   parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata: [63:0] cell_row
   input  logic [lgs_pkg::CELL_WORD_BITS-1:0]    req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: [63:0] next_row, [75:64] row_index, [79:76] zero
   output logic [lgs_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // csr_wdata: row_width
   input  logic [lgs_pkg::WIDTH_CSR_BITS-1:0]    csr_wdata,
   input  logic                                  csr_we
);

   localparam int CW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
   localparam logic [CW-1:0] ROW_LAST = CW'(MAX_ROWS - 1);
   localparam int PW = lgs_pkg::RESULT_PTR_BITS;
   localparam int QW = lgs_pkg::RESULT_CNT_BITS;

   // Configuration
   logic [lgs_pkg::WIDTH_CSR_BITS-1:0] width_ff, width_in;

   // Row window
   logic [ROW_BITS-1:0] above_ff, above_in;
   logic [ROW_BITS-1:0] middle_ff, middle_in;
   logic                mvalid_ff, mvalid_in;
   logic [CW-1:0]       rowcnt_ff, rowcnt_in;

   // Result queue
   lgs_pkg::result_type queue_ff [lgs_pkg::RESULT_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QW-1:0]       count_ff, count_in;

   logic                req_fire;
   logic                rsp_fire;
   logic                push_a;
   logic                push_b;
   logic [ROW_BITS-1:0] col_mask;
   logic [ROW_BITS-1:0] cur_row;
   logic [ROW_BITS-1:0] flush_above;
   logic [ROW_BITS-1:0] res_a;
   logic [ROW_BITS-1:0] res_b;
   logic [ROW_BITS-1:0] zero_row;
   logic [CW-1:0]       cnt_inc;
   logic [CW-1:0]       cnt_b;
   logic [PW-1:0]       wr_ptr_b;
   lgs_pkg::result_type entry_a;
   lgs_pkg::result_type entry_b;
   lgs_pkg::result_type head;

   assign req_tready = (count_ff <= QW'(lgs_pkg::RESULT_DEPTH - 2));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Active column mask, clamped to ROW_BITS by construction
   for (genvar j = 0; j < ROW_BITS; j++) begin : g_mask
      assign col_mask[j] = (width_ff > lgs_pkg::WIDTH_CSR_BITS'(j));
   end

   assign cur_row     = req_tdata[ROW_BITS-1:0] & col_mask;
   assign flush_above = mvalid_ff ? middle_ff : '0;
   assign zero_row    = '0;

   // Pending middle row, closed by the incoming row
   lgs_row_evolve #(.ROW_BITS(ROW_BITS)) u_evolve_mid (
      .row_up   (above_ff),
      .row_mid  (middle_ff),
      .row_dn   (cur_row),
      .col_mask (col_mask),
      .row_next (res_a)
   );

   // Bottom row flushed against an all-dead row below
   lgs_row_evolve #(.ROW_BITS(ROW_BITS)) u_evolve_last (
      .row_up   (flush_above),
      .row_mid  (cur_row),
      .row_dn   (zero_row),
      .col_mask (col_mask),
      .row_next (res_b)
   );

   assign push_a  = req_fire && mvalid_ff;
   assign push_b  = req_fire && req_tlast;
   assign cnt_inc = (rowcnt_ff < ROW_LAST) ? rowcnt_ff + CW'(1) : rowcnt_ff;
   assign cnt_b   = mvalid_ff ? cnt_inc : rowcnt_ff;

   always_comb begin
      entry_a.next_row  = lgs_pkg::CELL_WORD_BITS'(res_a);
      entry_a.row_index = lgs_pkg::ROW_INDEX_BITS'(rowcnt_ff);
      entry_a.board_end = 1'b0;
      entry_b.next_row  = lgs_pkg::CELL_WORD_BITS'(res_b);
      entry_b.row_index = lgs_pkg::ROW_INDEX_BITS'(cnt_b);
      entry_b.board_end = 1'b1;
   end

   // Window and counter update
   always_comb begin
      width_in  = csr_we ? csr_wdata : width_ff;
      above_in  = above_ff;
      middle_in = middle_ff;
      mvalid_in = mvalid_ff;
      rowcnt_in = rowcnt_ff;
      if (req_fire) begin
         if (req_tlast) begin
            // board done: back to the reset window
            above_in  = '0;
            middle_in = '0;
            mvalid_in = 1'b0;
            rowcnt_in = '0;
         end else begin
            above_in  = flush_above;
            middle_in = cur_row;
            mvalid_in = 1'b1;
            rowcnt_in = cnt_b;
         end
      end
   end

   // Queue pointers
   assign wr_ptr_b  = wr_ptr_ff + PW'(push_a);
   assign wr_ptr_in = wr_ptr_ff + PW'(push_a) + PW'(push_b);
   assign rd_ptr_in = rd_ptr_ff + PW'(rsp_fire);
   assign count_in  = count_ff + QW'(push_a) + QW'(push_b) - QW'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lgs_pkg::WIDTH_RESET;
         above_ff  <= '0;
         middle_ff <= '0;
         mvalid_ff <= 1'b0;
         rowcnt_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         above_ff  <= above_in;
         middle_ff <= middle_in;
         mvalid_ff <= mvalid_in;
         rowcnt_ff <= rowcnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage: up to two words written per accepted row
   always_ff @(posedge clock) begin
      if (push_a) begin
         queue_ff[wr_ptr_ff] <= entry_a;
      end
      if (push_b) begin
         queue_ff[wr_ptr_b] <= entry_b;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = head.board_end;
   assign rsp_tdata  = {{(lgs_pkg::RSP_TDATA_BITS - lgs_pkg::CELL_WORD_BITS
                          - lgs_pkg::ROW_INDEX_BITS){1'b0}},
                        head.row_index, head.next_row};

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QW'(lgs_pkg::RESULT_DEPTH))
      else $error("result queue over capacity");

   a_middle_clear: assert property (@(posedge clock) disable iff (reset)
      !mvalid_ff |-> (middle_ff == '0))
      else $error("stale middle row without valid");

   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (!mvalid_ff && (rowcnt_ff == '0)))
      else $error("window not cleared after last row");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (count_ff >= $past(count_ff)))
      else $error("result dropped under stall");

   a_end_pair: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast && mvalid_ff) |=> (count_ff >= QW'(2)))
      else $error("last row did not queue two results");
`endif

endmodule

@@ rtl/core/lgs_cell_lane.sv @@
module lgs_cell_lane (
   input  lgs_pkg::nbhd_type nbhd,
   output logic              next_cell
);

   logic [3:0] live_count;

   // Count the eight neighbors; the center cell is not one of them
   assign live_count = 4'($countones({nbhd.up, nbhd.mid[2], nbhd.mid[0], nbhd.dn}));

   assign next_cell = (live_count == lgs_pkg::BIRTH_COUNT) ||
                      (nbhd.mid[1] && (live_count == lgs_pkg::SURVIVE_COUNT));

endmodule

@@ rtl/core/lgs_row_evolve.sv @@
module lgs_row_evolve #(
   parameter int ROW_BITS = lgs_pkg::DEF_ROW_BITS
) (
   input  logic [ROW_BITS-1:0] row_up,
   input  logic [ROW_BITS-1:0] row_mid,
   input  logic [ROW_BITS-1:0] row_dn,
   input  logic [ROW_BITS-1:0] col_mask,
   output logic [ROW_BITS-1:0] row_next
);

   logic [ROW_BITS+1:0] pad_up;
   logic [ROW_BITS+1:0] pad_mid;
   logic [ROW_BITS+1:0] pad_dn;
   logic [ROW_BITS-1:0] lane_out;

   // Dead columns on both edges
   assign pad_up  = {1'b0, row_up,  1'b0};
   assign pad_mid = {1'b0, row_mid, 1'b0};
   assign pad_dn  = {1'b0, row_dn,  1'b0};

   for (genvar j = 0; j < ROW_BITS; j++) begin : g_lane
      lgs_pkg::nbhd_type nb;

      assign nb.up  = pad_up[j+2:j];
      assign nb.mid = pad_mid[j+2:j];
      assign nb.dn  = pad_dn[j+2:j];

      lgs_cell_lane u_lane (
         .nbhd      (nb),
         .next_cell (lane_out[j])
      );
   end

   // Merge the lanes and drop columns beyond the active width
   assign row_next = lane_out & col_mask;

endmodule

@@ sim/life_checker.sv @@
`timescale 1ns / 100ps

module life_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lgs_pkg::CELL_WORD_BITS-1:0] req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [lgs_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                               rsp_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [lgs_pkg::WIDTH_CSR_BITS-1:0] csr_wdata,
   input  logic                               csr_we,
   output int                                 fail_count,
   output int                                 pending
);

   localparam int CELL_BITS  = lgs_pkg::CELL_WORD_BITS;
   localparam int INDEX_BITS = lgs_pkg::ROW_INDEX_BITS;
   localparam int CSR_BITS   = lgs_pkg::WIDTH_CSR_BITS;
   localparam int LAST_INDEX = lgs_pkg::DEF_MAX_ROWS - 1;

   lgs_pkg::result_type       due_rows[$];
   logic [CSR_BITS-1:0]       width_now = lgs_pkg::WIDTH_RESET;
   logic [CELL_BITS-1:0]      row_up    = '0;
   logic [CELL_BITS-1:0]      row_mid   = '0;
   logic                      mid_held  = 1'b0;
   int                        rows_out   = 0;
   int                        mismatches = 0;

   // Columns at or beyond the width are dead; widths above the row size clamp
   function automatic logic [CELL_BITS-1:0] live_mask(input logic [CSR_BITS-1:0] w);
      if (w >= CELL_BITS)
         return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   function automatic logic [CELL_BITS-1:0] next_gen(
      input logic [CELL_BITS-1:0] up,
      input logic [CELL_BITS-1:0] mid,
      input logic [CELL_BITS-1:0] dn,
      input logic [CELL_BITS-1:0] mask
   );
      logic [CELL_BITS+1:0] u, m, d;
      logic [CELL_BITS-1:0] res;
      int unsigned          n;
      // pad one dead column on each side; column j sits at bit j+1
      u   = {1'b0, up, 1'b0};
      m   = {1'b0, mid, 1'b0};
      d   = {1'b0, dn, 1'b0};
      res = '0;
      for (int j = 0; j < CELL_BITS; j++) begin
         n = u[j] + u[j+1] + u[j+2] + m[j] + m[j+2] + d[j] + d[j+1] + d[j+2];
         res[j] = (n == lgs_pkg::BIRTH_COUNT) ||
                  (m[j+1] && n == lgs_pkg::SURVIVE_COUNT);
      end
      return res & mask;
   endfunction

   function automatic void queue_result(input logic [CELL_BITS-1:0] cells, input logic last);
      lgs_pkg::result_type r;
      r.next_row  = cells;
      r.row_index = INDEX_BITS'(rows_out);
      r.board_end = last;
      due_rows.insert(due_rows.size(), r);
      if (rows_out < LAST_INDEX)
         rows_out++;
   endfunction

   function automatic void note(input string field, input logic [CELL_BITS-1:0] want,
                                input logic [CELL_BITS-1:0] got);
      mismatches++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      lgs_pkg::result_type  want;
      logic [CELL_BITS-1:0] mask;
      logic [CELL_BITS-1:0] cur;
      if (reset) begin
         due_rows.delete();
         width_now = lgs_pkg::WIDTH_RESET;
         row_up    = '0;
         row_mid   = '0;
         mid_held  = 1'b0;
         rows_out  = 0;
      end else begin
         // results are registered before they leave, so check before predicting
         if (rsp_tvalid && rsp_tready) begin
            if (due_rows.size() == 0) begin
               mismatches++;
               $display("%0t unexpected result word: expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = due_rows.pop_front();
               if (rsp_tdata[CELL_BITS-1:0] !== want.next_row)
                  note("next_row", want.next_row, rsp_tdata[CELL_BITS-1:0]);
               if (rsp_tdata[CELL_BITS +: INDEX_BITS] !== want.row_index)
                  note("row_index", CELL_BITS'(want.row_index),
                       CELL_BITS'(rsp_tdata[CELL_BITS +: INDEX_BITS]));
               if (rsp_tlast !== want.board_end)
                  note("board_end", CELL_BITS'(want.board_end), CELL_BITS'(rsp_tlast));
            end
         end
         if (csr_we)
            width_now = csr_wdata;
         if (req_tvalid && req_tready) begin
            mask = live_mask(width_now);
            cur  = req_tdata & mask;
            if (mid_held) begin
               queue_result(next_gen(row_up, row_mid, cur, mask), 1'b0);
               row_up = row_mid;
            end else begin
               row_up = '0;
            end
            row_mid  = cur;
            mid_held = 1'b1;
            if (req_tlast) begin
               queue_result(next_gen(row_up, row_mid, '0, mask), 1'b1);
               row_up   = '0;
               row_mid  = '0;
               mid_held = 1'b0;
               rows_out = 0;
            end
         end
      end
      fail_count <= mismatches;
      pending    <= due_rows.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

   // Longest run of cycles with no word moving on either channel
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 12;
   localparam int PHASE_ROWS  = 75;
   localparam int CELL_BITS   = lgs_pkg::CELL_WORD_BITS;
   localparam int CSR_BITS    = lgs_pkg::WIDTH_CSR_BITS;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   // tdata: [63:0] cell_row
   logic [CELL_BITS-1:0]      req_tdata  = '0;
   logic                      req_tlast  = 1'b0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // tdata: [63:0] next_row, [75:64] row_index, [79:76] zero
   logic [lgs_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [CSR_BITS-1:0]       csr_wdata  = '0;
   logic                      csr_we     = 1'b0;

   // Set during one phase: neither side inserts bubbles
   logic                      no_gaps    = 1'b0;
   // Row word taken at the last rising edge; read by the sender at the falling edge
   logic                      req_fire   = 1'b0;
   int                        quiet_cycles = 0;
   int                        fail_count;
   int                        pending;
   int                        rows_sent   = 0;
   int                        boards_sent = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   life_generation_step i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wdata  (csr_wdata),
      .csr_we     (csr_we)
   );

   life_checker i_check (.*);

   // Stall the result side about a quarter of the time
   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= 24);
   end

   // Record acceptance and end the run if the channels go quiet for too long
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL life_generation_step");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mix of sparse, crowded and even boards
   function automatic logic [CELL_BITS-1:0] random_cells();
      logic [CELL_BITS-1:0] a, b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(3))
         0: begin
            return a & b;
         end
         1: begin
            return a | b;
         end
         2: begin
            return a;
         end
         default: begin
            return a & b & {$urandom, $urandom};
         end
      endcase
   endfunction

   // Offer one row word, maybe after a few bubbles, and hold it until taken.
   // Return at the falling edge after acceptance with tvalid still high.
   task automatic send_row(input logic [CELL_BITS-1:0] cells, input logic last);
      if (!no_gaps) begin
         while ($urandom_range(99) < 24) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tdata  <= cells;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(negedge clock);
      while (!req_fire) @(negedge clock);
      rows_sent++;
      if (last)
         boards_sent++;
   endtask

   // Drop valid, drain every expected result, then allow the pipeline to go quiet:
   // a first row of a board leaves nothing to wait on.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write the row width only when the block is idle; a board may still be open
   task automatic set_width(input logic [CSR_BITS-1:0] w);
      settle();
      csr_wdata <= w;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Lone row that is also the bottom row: the two end cells die
      send_row('1, 1'b1);
      // Vertical blinker turns horizontal around the middle row
      send_row(64'h0, 1'b0);
      send_row(64'h10, 1'b0);
      send_row(64'h10, 1'b0);
      send_row(64'h10, 1'b0);
      send_row(64'h0, 1'b1);
      // Live cells on both outer columns must not wrap around
      send_row(64'hC000_0000_0000_0003, 1'b0);
      send_row(64'hC000_0000_0000_0003, 1'b0);
      send_row('1, 1'b0);
      send_row(64'h0, 1'b1);
      // One column in use
      set_width(7'd1);
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // No columns in use: everything dies
      set_width(7'd0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // Width above the row size clamps to the full row
      set_width(7'd127);
      send_row(64'h8000_0000_0000_0001, 1'b1);
      set_width(7'd63);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // Change the width while a row is held
      send_row('1, 1'b0);
      set_width(7'd5);
      send_row('1, 1'b1);

      // Random boards; a board may run across a width change
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               set_width(7'd64);
            end
            1: begin
               set_width(7'd1);
            end
            2: begin
               set_width(7'd0);
            end
            3: begin
               set_width(7'd127);
            end
            4: begin
               set_width(7'd63);
            end
            5: begin
               set_width(7'd2);
            end
            default: begin
               set_width(CSR_BITS'($urandom_range(64, 3)));
            end
         endcase
         no_gaps = (p == 7);
         for (int k = 0; k < PHASE_ROWS; k++)
            send_row(random_cells(), $urandom_range(9) == 0);
      end
      no_gaps = 1'b0;

      // Drain, then give stray words a chance to show up
      settle();
      repeat (8) @(negedge clock);

      $display("Sent %0d row words in %0d boards at widths 0, 1, 2, 63, 64, 127 and random,",
               rows_sent, boards_sent);
      $display("with width changes inside open boards and one phase free of bubbles.");
      if (fail_count == 0 && pending == 0) begin
         $display("PASS life_generation_step");
      end else begin
         $display("FAIL life_generation_step");
      end
      $finish;
   end

endmodule
